@@ rtl/lfsf_pkg.sv @@
`timescale 1ns / 1ps

package lfsf_pkg;

	localparam int DIM_W  = 11;
	localparam int POS_W  = 10;
	localparam int SYM_W  = 8;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// register indexes on the configuration port
	localparam logic [1:0] REG_COLS = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;
	localparam logic [1:0] REG_OBST = 2'd2;

	localparam logic [DIM_W-1:0] RST_COLS = 11'd1;
	localparam logic [DIM_W-1:0] RST_ROWS = 11'd1;
	localparam logic [SYM_W-1:0] RST_OBST = 8'd111;

	typedef struct packed {
		logic             obst;
		logic             first_row;
		logic             first_col;
		logic             last;
		logic [POS_W-1:0] row;
		logic [DIM_W-1:0] col;
	} cell_t;

endpackage

@@ rtl/lfsf_ram.sv @@
`timescale 1ns / 1ps

module lfsf_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/lfsf_front.sv @@
`timescale 1ns / 1ps

module lfsf_front #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        cell_valid,
	output logic                        cell_stall,
	input  logic [lfsf_pkg::SYM_W-1:0]  cell_symbol,
	input  logic                        q_full,
	output logic                        push,
	output lfsf_pkg::cell_t             push_cell,
	output logic                        restart
);

	localparam logic [16:0] MAX_C = 17'(MAX_COLS);
	localparam logic [16:0] MAX_R = 17'(MAX_ROWS);

	logic [lfsf_pkg::DIM_W-1:0] cols_q, rows_q;
	logic [lfsf_pkg::SYM_W-1:0] obst_q;
	logic [lfsf_pkg::DIM_W-1:0] row_q, col_q;
	logic [lfsf_pkg::DIM_W-1:0] cols_eff, rows_eff;
	logic                       wr_en, accept, row_end, last;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			lfsf_pkg::REG_COLS: prdata = 32'(cols_q);
			lfsf_pkg::REG_ROWS: prdata = 32'(rows_q);
			lfsf_pkg::REG_OBST: prdata = 32'(obst_q);
			default:            prdata = 32'd0;
		endcase
	end

	// a dimension of zero counts as one, anything above the maximum as the maximum
	always_comb begin
		if (cols_q == '0) begin
			cols_eff = lfsf_pkg::DIM_W'(1);
		end else if (17'(cols_q) > MAX_C) begin
			cols_eff = MAX_C[lfsf_pkg::DIM_W-1:0];
		end else begin
			cols_eff = cols_q;
		end
		if (rows_q == '0) begin
			rows_eff = lfsf_pkg::DIM_W'(1);
		end else if (17'(rows_q) > MAX_R) begin
			rows_eff = MAX_R[lfsf_pkg::DIM_W-1:0];
		end else begin
			rows_eff = rows_q;
		end
	end

	assign restart    = wr_en && (paddr[3:2] == lfsf_pkg::REG_COLS ||
	                              paddr[3:2] == lfsf_pkg::REG_ROWS);
	assign cell_stall = q_full;
	assign accept     = cell_valid && !q_full;
	assign push       = accept;

	assign row_end = (12'(col_q) + 12'd1) >= 12'(cols_eff);
	assign last    = row_end && ((12'(row_q) + 12'd1) >= 12'(rows_eff));

	always_comb begin
		push_cell.obst      = (cell_symbol == obst_q);
		push_cell.first_row = (row_q == '0);
		push_cell.first_col = (col_q == '0);
		push_cell.last      = last;
		push_cell.row       = row_q[lfsf_pkg::POS_W-1:0];
		push_cell.col       = col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= lfsf_pkg::RST_COLS;
			rows_q <= lfsf_pkg::RST_ROWS;
			obst_q <= lfsf_pkg::RST_OBST;
			row_q  <= '0;
			col_q  <= '0;
		end else begin
			if (wr_en) begin
				unique case (paddr[3:2])
					lfsf_pkg::REG_COLS: cols_q <= pwdata[lfsf_pkg::DIM_W-1:0];
					lfsf_pkg::REG_ROWS: rows_q <= pwdata[lfsf_pkg::DIM_W-1:0];
					lfsf_pkg::REG_OBST: obst_q <= pwdata[lfsf_pkg::SYM_W-1:0];
					default: ;
				endcase
			end
			if (restart) begin
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				priority if (last) begin
					row_q <= '0;
					col_q <= '0;
				end else if (row_end) begin
					row_q <= row_q + 1'b1;
					col_q <= '0;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/lfsf_queue.sv @@
`timescale 1ns / 1ps

module lfsf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lfsf_pkg::cell_t push_cell,
	output logic            full,
	input  logic            pop,
	output lfsf_pkg::cell_t head,
	output logic            empty
);

	lfsf_pkg::cell_t                entry_q [lfsf_pkg::QDEPTH];
	logic [lfsf_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [lfsf_pkg::QCNT_W-1:0]    count_q;

	assign full  = (count_q == lfsf_pkg::QCNT_W'(lfsf_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

@@ rtl/lfsf_back.sv @@
`timescale 1ns / 1ps

module lfsf_back #(
	parameter int MAX_COLS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        restart,
	input  logic                        q_empty,
	input  lfsf_pkg::cell_t             head,
	output logic                        pop,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [lfsf_pkg::DIM_W-1:0]  cell_size,
	output logic [lfsf_pkg::DIM_W-1:0]  best_size,
	output logic [lfsf_pkg::POS_W-1:0]  best_row,
	output logic [lfsf_pkg::POS_W-1:0]  best_col,
	output logic                        map_done
);

	// a column index never exceeds the column register's range
	localparam int LB_DEPTH = (MAX_COLS < (1 << lfsf_pkg::DIM_W)) ? MAX_COLS
	                          : (1 << lfsf_pkg::DIM_W);
	localparam int LB_AW    = (LB_DEPTH > 1) ? $clog2(LB_DEPTH) : 1;

	localparam int W = lfsf_pkg::DIM_W;

	lfsf_pkg::cell_t cell_s1;
	logic            s1_valid_q;
	logic            fwd_hit_s1;
	logic [W-1:0]    fwd_data_s1;

	logic [W-1:0]    left_q, diag_q;
	logic [W-1:0]    best_size_q;
	logic [lfsf_pkg::POS_W-1:0] best_row_q, best_col_q;

	logic            out_valid_q, map_done_q;
	logic [W-1:0]    cell_size_q, out_best_size_q;
	logic [lfsf_pkg::POS_W-1:0] out_best_row_q, out_best_col_q;

	logic [W-1:0]    rd_data, up, lf, dg, m1, m2, size;
	logic            adv, load, new_best;
	logic [LB_AW-1:0] waddr, raddr;

	assign adv   = s1_valid_q && (!out_valid_q || !result_stall);
	assign load  = !q_empty && (!s1_valid_q || adv);
	assign pop   = load;
	assign waddr = cell_s1.col[LB_AW-1:0];
	assign raddr = head.col[LB_AW-1:0];

	lfsf_ram #(
		.WIDTH(W),
		.DEPTH(LB_DEPTH)
	) u_line_buf (
		.clk  (clk),
		.we   (adv),
		.waddr(waddr),
		.wdata(size),
		.re   (load),
		.raddr(raddr),
		.rdata(rd_data)
	);

	// take the size being written in the read cycle, the memory returns the old word
	always_comb begin
		up = cell_s1.first_row ? '0 : (fwd_hit_s1 ? fwd_data_s1 : rd_data);
		lf = cell_s1.first_col ? '0 : left_q;
		dg = (cell_s1.first_row || cell_s1.first_col) ? '0 : diag_q;
		m1 = (up < lf) ? up : lf;
		m2 = (m1 < dg) ? m1 : dg;
		size = cell_s1.obst ? '0 : (m2 + 1'b1);
		new_best = (size > best_size_q);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cell_s1     <= head;
			fwd_hit_s1  <= adv && (waddr == raddr);
			fwd_data_s1 <= size;
		end
		if (adv) begin
			cell_size_q     <= size;
			out_best_size_q <= new_best ? size : best_size_q;
			out_best_row_q  <= new_best ? cell_s1.row : best_row_q;
			out_best_col_q  <= new_best ? cell_s1.col[lfsf_pkg::POS_W-1:0] : best_col_q;
			map_done_q      <= cell_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
			diag_q      <= '0;
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else begin
			if (load) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (restart) begin
				left_q      <= '0;
				diag_q      <= '0;
				best_size_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else if (adv) begin
				left_q <= size;
				diag_q <= up;
				// clear the best at the end of a map so the next one starts fresh
				priority if (cell_s1.last) begin
					best_size_q <= '0;
					best_row_q  <= '0;
					best_col_q  <= '0;
				end else if (new_best) begin
					best_size_q <= size;
					best_row_q  <= cell_s1.row;
					best_col_q  <= cell_s1.col[lfsf_pkg::POS_W-1:0];
				end
			end
		end
	end

	assign result_valid = out_valid_q;
	assign cell_size    = cell_size_q;
	assign best_size    = out_best_size_q;
	assign best_row     = out_best_row_q;
	assign best_col     = out_best_col_q;
	assign map_done     = map_done_q;

	a_best_covers_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_best_size_q >= cell_size_q))
		else $error("best size below the size of the cell shown");

	a_best_clears_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cell_s1.last) |=> (best_size_q == '0))
		else $error("best size kept across the end of a map");

	a_adv_needs_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_stall) |-> !adv)
		else $error("result register overwritten while stalled");

endmodule

@@ rtl/largest_free_square_finder_top.sv @@
// An accepted cell passes the queue, the stage register and the result register in turn.
// Throughput: one cell per cycle without result_stall, one line-buffer read and write each.
// A four-entry queue parts the input from the line-buffer stage, so either side may stall.
// Reset: arst_n clears counters, best tracking and handshake state asynchronously.
// The line buffer is not cleared; an entry is always written before a map reads it.
`timescale 1ns / 1ps

module largest_free_square_finder_top #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        cell_valid,
	output logic                        cell_stall,
	input  logic [lfsf_pkg::SYM_W-1:0]  cell_symbol,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [lfsf_pkg::DIM_W-1:0]  cell_size,
	output logic [lfsf_pkg::DIM_W-1:0]  best_size,
	output logic [lfsf_pkg::POS_W-1:0]  best_row,
	output logic [lfsf_pkg::POS_W-1:0]  best_col,
	output logic                        map_done
);

	lfsf_pkg::cell_t push_cell, head;
	logic            push, pop, q_full, q_empty, restart;

	lfsf_front #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_symbol(cell_symbol),
		.q_full     (q_full),
		.push       (push),
		.push_cell  (push_cell),
		.restart    (restart)
	);

	lfsf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cell(push_cell),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	lfsf_back #(
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (restart),
		.q_empty     (q_empty),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cell_size   (cell_size),
		.best_size   (best_size),
		.best_row    (best_row),
		.best_col    (best_col),
		.map_done    (map_done)
	);

endmodule
